// ===== src/dsp_pkg.sv =====
package dsp_pkg;

   // Fixed field widths of the request and response words.
   localparam int VTX_W   = 10;
   localparam int WT_W    = 16;
   localparam int DIST_W  = 32;
   localparam int CNT_W   = 13;

   // Command codes.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_RUN   = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [DIST_W-1:0] UNREACHED = '1;
   localparam logic [DIST_W-1:0] DIST_CAP  = 32'hFFFF_FFFE;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [VTX_W-1:0] edge_from;
      logic [VTX_W-1:0] edge_to;
      logic [WT_W-1:0]  edge_weight;
      logic [VTX_W-1:0] vertex;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DIST_W-1:0] distance;
      logic              reachable;
      logic [VTX_W-1:0]  parent;
      logic              has_parent;
      logic [CNT_W-1:0]  edge_count;
   } rsp_type;

   // One word of the per-vertex search table.
   typedef struct packed {
      logic              visited;
      logic              has_parent;
      logic [VTX_W-1:0]  parent;
      logic [DIST_W-1:0] distance;
   } vtx_entry_type;

   // Priority queue key, ordered by distance and then by vertex.
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [VTX_W-1:0]  vertex;
   } key_type;

   localparam vtx_entry_type VTX_RESET = '{1'b0, 1'b0, {VTX_W{1'b0}}, UNREACHED};

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_CLR, S_ADD, S_ADD_LST, S_ADD_LNK, S_QRY, S_QRY_DAT,
      S_RUN, S_RUN_CLR, S_POP, S_POP_TOP, S_POP_LAST, S_SIFT, S_SIFT_L,
      S_SIFT_R, S_SIFT_CMP, S_VIS_RD, S_VIS_CHK, S_EDGE, S_EDGE_DAT, S_REL,
      S_PUSH, S_PUSH_CMP, S_DONE
   } state_type;

endpackage

// ===== src/dsp_ram.sv =====
module dsp_ram
   import dsp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dijkstra_shortest_paths.sv =====
// Single-source shortest paths engine. Each request word clears the edge store,
// appends an edge, runs a search from a source vertex or queries one vertex, and
// gives exactly one response word. Graph, search table and the binary-heap
// priority queue live in RAMs with one write port and one registered read port,
// and one request is worked at a time. After reset a clearing pass over the
// adjacency list and search tables runs before the first request is taken. A run
// first resets the search table, then pops the queue, sifting the last entry down,
// and walks the edges of each popped vertex, sifting each relaxed key up the heap.
module dijkstra_shortest_paths
   import dsp_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [9:0] csr_wr_data
);

   localparam int VAW    = $clog2(MAX_VERTICES);
   localparam int EAW    = $clog2(MAX_EDGES);
   localparam int ECW    = $clog2(MAX_EDGES + 1);
   localparam int QCAP   = MAX_EDGES + 1;
   localparam int HAW    = $clog2(QCAP);
   localparam int HSW    = $clog2(QCAP + 1);
   localparam int LIST_W = 2 * ECW;
   localparam int EDGE_W = VTX_W + WT_W + ECW;
   localparam int VENT_W = $bits(vtx_entry_type);
   localparam int KEY_W  = $bits(key_type);

   localparam logic [ECW-1:0] EMPTY_LINK = ECW'(MAX_EDGES);
   localparam logic [VAW-1:0] LAST_VTX   = VAW'(MAX_VERTICES - 1);

   // Registers.
   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [9:0]           vcount_ff, vcount_in;
   logic [ECW-1:0]       edges_ff, edges_in;
   logic [VAW-1:0]       sweep_ff, sweep_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [HSW-1:0]       qsize_ff, qsize_in;
   logic [HAW-1:0]       hole_ff, hole_in;
   key_type              key_ff, key_in;
   key_type              top_ff, top_in;
   key_type              child_ff, child_in;
   logic [HAW-1:0]       cidx_ff, cidx_in;
   logic [ECW-1:0]       eptr_ff, eptr_in;
   logic [ECW-1:0]       tail_ff, tail_in;
   logic [VTX_W-1:0]     dest_ff, dest_in;
   logic [WT_W-1:0]      cost_ff, cost_in;

   // Memory ports.
   logic                 list_we;
   logic [VAW-1:0]       list_wa, list_ra;
   logic [LIST_W-1:0]    list_wd, list_rd;
   logic                 edge_we;
   logic [EAW-1:0]       edge_wa, edge_ra;
   logic [EDGE_W-1:0]    edge_wd, edge_rd;
   logic                 vtx_we;
   logic [VAW-1:0]       vtx_wa, vtx_ra;
   vtx_entry_type        vtx_wd, vtx_rd;
   logic [VENT_W-1:0]    vtx_rd_raw;
   logic                 heap_we;
   logic [HAW-1:0]       heap_wa, heap_ra;
   key_type              heap_wd, heap_rd;
   logic [KEY_W-1:0]     heap_rd_raw;

   // Helper values.
   logic                 out_free;
   logic [ECW-1:0]       lst_head, lst_tail;
   logic [VTX_W-1:0]     ed_dest;
   logic [WT_W-1:0]      ed_cost;
   logic [ECW-1:0]       ed_next;
   logic [HAW+1:0]       lft, rgt, qsize_x;
   logic [HSW-1:0]       qdec;
   logic [HAW-1:0]       hole_m1, hparent;
   logic [DIST_W:0]      sum;
   logic [DIST_W-1:0]    nd;
   vtx_entry_type        vtx_new;

   function automatic logic in_range(input logic [VTX_W-1:0] v, input logic [9:0] cnt);
      in_range = (v != '0) && (v <= cnt) && (32'(v) < MAX_VERTICES);
   endfunction

   dsp_ram #(.WIDTH(LIST_W), .DEPTH(MAX_VERTICES)) u_list_ram (
      .clock(clock), .wr_en(list_we), .wr_addr(list_wa), .wr_data(list_wd),
      .rd_addr(list_ra), .rd_data(list_rd)
   );

   dsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_addr(edge_ra), .rd_data(edge_rd)
   );

   dsp_ram #(.WIDTH(VENT_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
      .clock(clock), .wr_en(vtx_we), .wr_addr(vtx_wa), .wr_data(vtx_wd),
      .rd_addr(vtx_ra), .rd_data(vtx_rd_raw)
   );

   dsp_ram #(.WIDTH(KEY_W), .DEPTH(QCAP)) u_heap_ram (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr(heap_ra), .rd_data(heap_rd_raw)
   );

   assign vtx_rd  = vtx_entry_type'(vtx_rd_raw);
   assign heap_rd = key_type'(heap_rd_raw);

   // Field views of memory words and heap index arithmetic.
   assign lst_head = list_rd[LIST_W-1:ECW];
   assign lst_tail = list_rd[ECW-1:0];
   assign ed_dest  = edge_rd[EDGE_W-1:WT_W+ECW];
   assign ed_cost  = edge_rd[WT_W+ECW-1:ECW];
   assign ed_next  = edge_rd[ECW-1:0];
   assign lft      = {1'b0, hole_ff, 1'b1};
   assign rgt      = lft + (HAW+2)'(1);
   assign qsize_x  = (HAW+2)'(qsize_ff);
   assign qdec     = qsize_ff - HSW'(1);
   assign hole_m1  = hole_ff - HAW'(1);
   assign hparent  = {1'b0, hole_m1[HAW-1:1]};

   // Relaxed distance, saturated just below the unreachable marker.
   assign sum = {1'b0, top_ff.distance} + (DIST_W+1)'(cost_ff);
   assign nd  = (sum[DIST_W] || (sum[DIST_W-1:0] == UNREACHED)) ? DIST_CAP
              : sum[DIST_W-1:0];

   assign vtx_new  = '{1'b0, 1'b1, top_ff.vertex, nd};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state, datapath and memory control.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      vcount_in    = csr_wr_en ? csr_wr_data : vcount_ff;
      edges_in     = edges_ff;
      sweep_in     = sweep_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      qsize_in     = qsize_ff;
      hole_in      = hole_ff;
      key_in       = key_ff;
      top_in       = top_ff;
      child_in     = child_ff;
      cidx_in      = cidx_ff;
      eptr_in      = eptr_ff;
      tail_in      = tail_ff;
      dest_in      = dest_ff;
      cost_in      = cost_ff;

      list_we = 1'b0;
      list_wa = sweep_ff;
      list_wd = {EMPTY_LINK, EMPTY_LINK};
      list_ra = VAW'(req_ff.edge_from);
      edge_we = 1'b0;
      edge_wa = EAW'(edges_ff);
      edge_wd = {req_ff.edge_to, req_ff.edge_weight, EMPTY_LINK};
      edge_ra = EAW'(eptr_ff);
      vtx_we  = 1'b0;
      vtx_wa  = sweep_ff;
      vtx_wd  = VTX_RESET;
      vtx_ra  = VAW'(req_ff.vertex);
      heap_we = 1'b0;
      heap_wa = hole_ff;
      heap_wd = key_ff;
      heap_ra = '0;

      case (state_ff)
         // Clearing pass after reset over the list and search tables.
         S_INIT: begin
            list_we  = 1'b1;
            vtx_we   = 1'b1;
            sweep_in = sweep_ff + VAW'(1);
            if (sweep_ff == LAST_VTX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               res_in   = '0;
               sweep_in = '0;
               case (req_data.cmd)
                  CMD_CLEAR: state_in = S_CLR;
                  CMD_ADD:   state_in = S_ADD;
                  CMD_RUN:   state_in = S_RUN;
                  CMD_QUERY: state_in = S_QRY;
                  default:   state_in = S_QRY;
               endcase
            end
         end

         // Empty every adjacency list.
         S_CLR: begin
            list_we  = 1'b1;
            sweep_in = sweep_ff + VAW'(1);
            if (sweep_ff == LAST_VTX) begin
               edges_in = '0;
               state_in = S_DONE;
            end
         end

         S_ADD: begin
            if (!in_range(req_ff.edge_from, vcount_ff)
                || !in_range(req_ff.edge_to, vcount_ff)) begin
               res_in.status = ST_RANGE;
               state_in      = S_DONE;
            end else if (edges_ff == EMPTY_LINK) begin
               res_in.status = ST_FULL;
               state_in      = S_DONE;
            end else begin
               state_in = S_ADD_LST;
            end
         end

         // Store the new edge and update head and tail of its source list.
         S_ADD_LST: begin
            edge_we = 1'b1;
            list_we = 1'b1;
            list_wa = VAW'(req_ff.edge_from);
            edge_ra = EAW'(lst_tail);
            tail_in = lst_tail;
            if (lst_head == EMPTY_LINK) begin
               list_wd  = {edges_ff, edges_ff};
               edges_in = edges_ff + ECW'(1);
               state_in = S_DONE;
            end else begin
               list_wd  = {lst_head, edges_ff};
               state_in = S_ADD_LNK;
            end
         end

         // Link the old tail edge to the new one.
         S_ADD_LNK: begin
            edge_we  = 1'b1;
            edge_wa  = EAW'(tail_ff);
            edge_wd  = {ed_dest, ed_cost, edges_ff};
            edges_in = edges_ff + ECW'(1);
            state_in = S_DONE;
         end

         S_QRY: begin
            if (!in_range(req_ff.vertex, vcount_ff)) begin
               res_in.status   = ST_RANGE;
               res_in.distance = UNREACHED;
               state_in        = S_DONE;
            end else begin
               state_in = S_QRY_DAT;
            end
         end

         S_QRY_DAT: begin
            res_in.distance   = vtx_rd.distance;
            res_in.reachable  = (vtx_rd.distance != UNREACHED);
            res_in.has_parent = vtx_rd.has_parent;
            res_in.parent     = vtx_rd.has_parent ? vtx_rd.parent : '0;
            state_in          = S_DONE;
         end

         S_RUN: begin
            if (!in_range(req_ff.vertex, vcount_ff)) begin
               res_in.status = ST_RANGE;
               state_in      = S_DONE;
            end else begin
               state_in = S_RUN_CLR;
            end
         end

         // Reset the search table, seed the source and the queue.
         S_RUN_CLR: begin
            vtx_we   = 1'b1;
            if (sweep_ff == VAW'(req_ff.vertex)) begin
               vtx_wd.distance = '0;
            end
            sweep_in = sweep_ff + VAW'(1);
            if (sweep_ff == LAST_VTX) begin
               heap_we  = 1'b1;
               heap_wa  = '0;
               heap_wd  = '{{DIST_W{1'b0}}, req_ff.vertex};
               qsize_in = HSW'(1);
               state_in = S_POP;
            end
         end

         S_POP: begin
            heap_ra = '0;
            if (qsize_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_POP_TOP;
            end
         end

         S_POP_TOP: begin
            top_in   = heap_rd;
            qsize_in = qdec;
            heap_ra  = HAW'(qdec);
            if (qdec == '0) begin
               state_in = S_VIS_RD;
            end else begin
               state_in = S_POP_LAST;
            end
         end

         S_POP_LAST: begin
            key_in   = heap_rd;
            hole_in  = '0;
            state_in = S_SIFT;
         end

         // Sift the last entry down from the root.
         S_SIFT: begin
            heap_ra = HAW'(lft);
            if (lft >= qsize_x) begin
               heap_we  = 1'b1;
               state_in = S_VIS_RD;
            end else begin
               state_in = S_SIFT_L;
            end
         end

         S_SIFT_L: begin
            child_in = heap_rd;
            cidx_in  = HAW'(lft);
            heap_ra  = HAW'(rgt);
            if (rgt < qsize_x) begin
               state_in = S_SIFT_R;
            end else begin
               state_in = S_SIFT_CMP;
            end
         end

         S_SIFT_R: begin
            if (heap_rd < child_ff) begin
               child_in = heap_rd;
               cidx_in  = HAW'(rgt);
            end
            state_in = S_SIFT_CMP;
         end

         S_SIFT_CMP: begin
            heap_we = 1'b1;
            if (child_ff < key_ff) begin
               heap_wd  = child_ff;
               hole_in  = cidx_ff;
               state_in = S_SIFT;
            end else begin
               state_in = S_VIS_RD;
            end
         end

         // Fetch the popped vertex's table word and list head.
         S_VIS_RD: begin
            vtx_ra   = VAW'(top_ff.vertex);
            list_ra  = VAW'(top_ff.vertex);
            state_in = S_VIS_CHK;
         end

         S_VIS_CHK: begin
            if (vtx_rd.visited) begin
               state_in = S_POP;
            end else begin
               vtx_we         = 1'b1;
               vtx_wa         = VAW'(top_ff.vertex);
               vtx_wd         = vtx_rd;
               vtx_wd.visited = 1'b1;
               eptr_in        = lst_head;
               state_in       = S_EDGE;
            end
         end

         // Walk the adjacency list of the popped vertex.
         S_EDGE: begin
            if (eptr_ff >= edges_ff) begin
               state_in = S_POP;
            end else begin
               state_in = S_EDGE_DAT;
            end
         end

         S_EDGE_DAT: begin
            eptr_in = ed_next;
            dest_in = ed_dest;
            cost_in = ed_cost;
            vtx_ra  = VAW'(ed_dest);
            if (in_range(ed_dest, vcount_ff)) begin
               state_in = S_REL;
            end else begin
               state_in = S_EDGE;
            end
         end

         // Relax on strict improvement and push the new key while the queue has room.
         S_REL: begin
            state_in = S_EDGE;
            if (!vtx_rd.visited && (nd < vtx_rd.distance)) begin
               vtx_we = 1'b1;
               vtx_wa = VAW'(dest_ff);
               vtx_wd = vtx_new;
               key_in = '{nd, dest_ff};
               if (32'(qsize_ff) < QCAP) begin
                  hole_in  = HAW'(qsize_ff);
                  qsize_in = qsize_ff + HSW'(1);
                  state_in = S_PUSH;
               end
            end
         end

         // Sift the pushed key up toward the root.
         S_PUSH: begin
            heap_ra = hparent;
            if (hole_ff == '0) begin
               heap_we  = 1'b1;
               state_in = S_EDGE;
            end else begin
               state_in = S_PUSH_CMP;
            end
         end

         S_PUSH_CMP: begin
            heap_we = 1'b1;
            if (heap_rd <= key_ff) begin
               state_in = S_EDGE;
            end else begin
               heap_wd  = heap_rd;
               hole_in  = hparent;
               state_in = S_PUSH;
            end
         end

         // Hand the finished word to the output register.
         S_DONE: begin
            if (out_free) begin
               rsp_in            = res_ff;
               rsp_in.edge_count = CNT_W'(edges_ff);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         vcount_ff    <= 10'd1023;
         edges_ff     <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         qsize_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         edges_ff     <= edges_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         qsize_ff     <= qsize_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      hole_ff  <= hole_in;
      key_ff   <= key_in;
      top_ff   <= top_in;
      child_ff <= child_in;
      cidx_ff  <= cidx_in;
      eptr_ff  <= eptr_in;
      tail_ff  <= tail_in;
      dest_ff  <= dest_in;
      cost_ff  <= cost_in;
   end

endmodule
